FILE: src/dtte_pkg.sv
// dtte_pkg: shared types, constants and lookup functions for the duration text parser
// no dependencies; compiled first
package dtte_pkg;

    localparam int CH_W   = 8;
    localparam int NOW_W  = 63;
    localparam int EXP_W  = 64;
    localparam int UNIT_W = 25;
    localparam int LEN_W  = 4;
    localparam int KW_N   = 3;

    localparam logic [UNIT_W-1:0] U_YEAR = UNIT_W'(365*24*60*60 + 24*60*60/4);
    localparam logic [UNIT_W-1:0] U_WEEK = UNIT_W'(7*24*60*60);
    localparam logic [UNIT_W-1:0] U_DAY  = UNIT_W'(24*60*60);
    localparam logic [UNIT_W-1:0] U_HOUR = UNIT_W'(60*60);
    localparam logic [UNIT_W-1:0] U_MIN  = UNIT_W'(60);
    localparam logic [UNIT_W-1:0] U_SEC  = UNIT_W'(1);

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_Y     = 8'h79;
    localparam logic [CH_W-1:0] CH_W_LC  = 8'h77;
    localparam logic [CH_W-1:0] CH_D     = 8'h64;
    localparam logic [CH_W-1:0] CH_H     = 8'h68;
    localparam logic [CH_W-1:0] CH_M     = 8'h6d;
    localparam logic [CH_W-1:0] CH_S     = 8'h73;

    localparam logic [1:0] KW_ALWAYS  = 2'd0;
    localparam logic [1:0] KW_FOREVER = 2'd1;
    localparam logic [1:0] KW_STAR    = 2'd2;

    typedef enum logic [2:0] {
        UNIT_SEC,
        UNIT_MIN,
        UNIT_HOUR,
        UNIT_DAY,
        UNIT_WEEK,
        UNIT_YEAR
    } t_unit;

    typedef struct packed {
        logic             kw;
        logic             failed;
        logic             no_cache;
        logic             absolute;
        logic [NOW_W-1:0] now;
    } t_term;

    typedef struct packed {
        logic  valid;
        logic  is_nul;
        logic  is_unit;
        t_unit unit;
        t_term term;
    } t_tag;

    function automatic logic [UNIT_W-1:0] unit_value(input t_unit u);
        logic [UNIT_W-1:0] v;
        case (u)
            UNIT_YEAR: v = U_YEAR;
            UNIT_WEEK: v = U_WEEK;
            UNIT_DAY:  v = U_DAY;
            UNIT_HOUR: v = U_HOUR;
            UNIT_MIN:  v = U_MIN;
            UNIT_SEC:  v = U_SEC;
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] kw_len(input logic [1:0] k);
        logic [LEN_W-1:0] n;
        case (k)
            KW_ALWAYS:  n = 4'd6;
            KW_FOREVER: n = 4'd7;
            KW_STAR:    n = 4'd1;
            default:    n = '0;
        endcase
        return n;
    endfunction

    // keyword letters, zero past the end
    function automatic logic [CH_W-1:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
        logic [CH_W-1:0] c;
        c = CH_NUL;
        case (k)
            KW_ALWAYS: begin
                case (idx)
                    3'd0:    c = 8'h61;
                    3'd1:    c = 8'h6c;
                    3'd2:    c = 8'h77;
                    3'd3:    c = 8'h61;
                    3'd4:    c = 8'h79;
                    3'd5:    c = 8'h73;
                    default: c = CH_NUL;
                endcase
            end
            KW_FOREVER: begin
                case (idx)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h6f;
                    3'd2:    c = 8'h72;
                    3'd3:    c = 8'h65;
                    3'd4:    c = 8'h76;
                    3'd5:    c = 8'h65;
                    3'd6:    c = 8'h72;
                    default: c = CH_NUL;
                endcase
            end
            KW_STAR: begin
                case (idx)
                    3'd0:    c = 8'h2a;
                    default: c = CH_NUL;
                endcase
            end
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

FILE: src/dtte_req_if.sv
// dtte_req_if: request channel carrying one text byte and the time sampled with it
// depends on dtte_pkg
interface dtte_req_if;
    import dtte_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  ch;
    logic             absolute_mode;
    logic [NOW_W-1:0] now_seconds;

    modport source (output valid, ch, absolute_mode, now_seconds, input ready);
    modport sink   (input valid, ch, absolute_mode, now_seconds, output ready);
endinterface

FILE: src/dtte_rsp_if.sv
// dtte_rsp_if: result channel carrying the parse status and the expiry value
// depends on dtte_pkg
interface dtte_rsp_if;
    import dtte_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [EXP_W-1:0] expiry_value;

    modport source (output valid, ok, expiry_value, input ready);
    modport sink   (input valid, ok, expiry_value, output ready);
endinterface

FILE: src/duration_text_to_expiry.sv
// duration_text_to_expiry: top level of the duration text parser
// depends on dtte_pkg, dtte_req_if, dtte_rsp_if, dtte_parse, dtte_mul, dtte_acc
//
// Takes one text byte per request, one request per clock unless stalled. A NUL
// byte closes the text and yields one result through the input, parse, multiply
// and sum registers; other bytes yield none. The rate is set by the per-byte
// parse state (the saturating digit multiply-add), which updates once a cycle
// unless stalled; the unit multiply runs in a two-stage split multiplier behind
// it. Requests keep flowing while a result waits, until a second NUL reaches
// the last stage. Values saturate at 2^(TIME_BITS-1)-1; a leading minus returns
// -(r+1). absolute_mode and now_seconds are taken with the NUL request.
module duration_text_to_expiry #(
    parameter int TIME_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtte_req_if.sink   i_req,
    dtte_rsp_if.source o_rsp
);
    import dtte_pkg::*;

    logic                 w_stall;
    logic                 w_en;
    t_tag                 w_tag1;
    logic [TIME_BITS-2:0] w_acc1;
    t_tag                 w_tag3;
    logic [TIME_BITS-2:0] w_val3;

    assign w_en = !w_stall;

    dtte_parse #(.TIME_BITS(TIME_BITS)) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (i_req),
        .o_tag   (w_tag1),
        .o_acc   (w_acc1)
    );

    dtte_mul #(.TIME_BITS(TIME_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag1),
        .i_acc   (w_acc1),
        .o_tag   (w_tag3),
        .o_val   (w_val3)
    );

    dtte_acc #(.TIME_BITS(TIME_BITS)) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag3),
        .i_val   (w_val3),
        .o_stall (w_stall),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: src/dtte_parse.sv
// dtte_parse: input register and per-character parse state (digits, keywords, prefix)
// depends on dtte_pkg and dtte_req_if; feeds dtte_mul
module dtte_parse #(
    parameter int TIME_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    dtte_req_if.sink          i_req,
    output dtte_pkg::t_tag    o_tag,
    output logic [TIME_BITS-2:0] o_acc
);
    import dtte_pkg::*;

    localparam int AW = TIME_BITS - 1;
    localparam longint unsigned TMAX_L = (64'd1 << AW) - 64'd1;
    localparam logic [AW-1:0] TMAX  = AW'(TMAX_L);
    localparam logic [AW-1:0] LIM10 = AW'(TMAX_L / 64'd10);

    logic             r_in_valid;
    logic [CH_W-1:0]  r_in_ch;
    logic             r_in_abs;
    logic [NOW_W-1:0] r_in_now;

    logic             r_first, n_first;
    logic             r_no_cache, n_no_cache;
    logic [LEN_W-1:0] r_len, n_len;
    logic [KW_N-1:0]  r_alive, n_alive;
    logic [AW-1:0]    r_acc, n_acc;
    logic             r_failed, n_failed;
    t_tag             r_tag, n_tag;
    logic [AW-1:0]    r_out_acc, n_out_acc;

    logic [AW+3:0]   w_mac;
    logic [AW-1:0]   w_acc_digit;
    logic [KW_N-1:0] w_len_hit;
    logic [KW_N-1:0] w_kill;
    logic            w_kw;
    logic            w_is_digit;
    logic            w_is_unit;
    t_unit           w_unit;

    // acc * 10 + digit, saturating
    assign w_mac = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                 + {{AW{1'b0}}, r_in_ch[3:0]};
    assign w_acc_digit = (r_acc > LIM10 || w_mac > {4'b0000, TMAX}) ? TMAX : w_mac[AW-1:0];

    always_comb begin
        for (int k = 0; k < KW_N; k++) begin
            w_len_hit[k] = (r_len == kw_len(2'(k)));
            w_kill[k]    = (r_len >= kw_len(2'(k))) || (kw_char(2'(k), r_len[2:0]) != r_in_ch);
        end
    end

    assign w_kw       = (r_len == '0) || |(r_alive & w_len_hit);
    assign w_is_digit = r_in_ch inside {[CH_0:CH_9]};

    always_comb begin
        w_is_unit = 1'b1;
        w_unit    = UNIT_SEC;
        case (r_in_ch)
            CH_Y:    w_unit = UNIT_YEAR;
            CH_W_LC: w_unit = UNIT_WEEK;
            CH_D:    w_unit = UNIT_DAY;
            CH_H:    w_unit = UNIT_HOUR;
            CH_M:    w_unit = UNIT_MIN;
            CH_S:    w_unit = UNIT_SEC;
            default: w_is_unit = 1'b0;
        endcase
    end

    always_comb begin
        n_first    = r_first;
        n_no_cache = r_no_cache;
        n_len      = r_len;
        n_alive    = r_alive;
        n_acc      = r_acc;
        n_failed   = r_failed;
        n_tag      = '0;
        n_out_acc  = r_acc;
        if (r_in_valid) begin
            if (r_in_ch == CH_NUL) begin
                n_tag.valid          = 1'b1;
                n_tag.is_nul         = 1'b1;
                n_tag.term.kw        = w_kw;
                n_tag.term.failed    = r_failed;
                n_tag.term.no_cache  = r_no_cache;
                n_tag.term.absolute  = r_in_abs;
                n_tag.term.now       = r_in_now;
                n_first    = 1'b1;
                n_no_cache = 1'b0;
                n_len      = '0;
                n_alive    = '1;
                n_acc      = '0;
                n_failed   = 1'b0;
            end else if (r_first && r_in_ch == CH_MINUS) begin
                n_first    = 1'b0;
                n_no_cache = 1'b1;
            end else begin
                n_first = 1'b0;
                n_alive = r_alive & ~w_kill;
                if (r_len != '1) begin
                    n_len = r_len + LEN_W'(1);
                end
                if (!r_failed) begin
                    if (w_is_digit) begin
                        n_acc = w_acc_digit;
                    end else if (w_is_unit) begin
                        n_tag.valid   = 1'b1;
                        n_tag.is_unit = 1'b1;
                        n_tag.unit    = w_unit;
                        n_acc         = '0;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
            end
        end
    end

    assign i_req.ready = i_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_first    <= 1'b1;
            r_no_cache <= 1'b0;
            r_len      <= '0;
            r_alive    <= '1;
            r_acc      <= '0;
            r_failed   <= 1'b0;
            r_tag      <= '0;
        end else if (i_en) begin
            r_in_valid <= i_req.valid;
            r_first    <= n_first;
            r_no_cache <= n_no_cache;
            r_len      <= n_len;
            r_alive    <= n_alive;
            r_acc      <= n_acc;
            r_failed   <= n_failed;
            r_tag      <= n_tag;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_ch   <= i_req.ch;
            r_in_abs  <= i_req.absolute_mode;
            r_in_now  <= i_req.now_seconds;
            r_out_acc <= n_out_acc;
        end
    end

    assign o_tag = r_tag;
    assign o_acc = r_out_acc;

endmodule

FILE: src/dtte_mul.sv
// dtte_mul: two-stage saturating multiply of the parsed digit value by the unit length
// depends on dtte_pkg; sits between dtte_parse and dtte_acc
module dtte_mul #(
    parameter int TIME_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  dtte_pkg::t_tag       i_tag,
    input  logic [TIME_BITS-2:0] i_acc,
    output dtte_pkg::t_tag       o_tag,
    output logic [TIME_BITS-2:0] o_val
);
    import dtte_pkg::*;

    localparam int AW = TIME_BITS - 1;
    localparam int LW = TIME_BITS / 2;
    localparam int HW = AW - LW;
    localparam int PW = AW + UNIT_W;
    localparam longint unsigned TMAX_L = (64'd1 << AW) - 64'd1;
    localparam logic [AW-1:0] TMAX     = AW'(TMAX_L);
    localparam logic [AW-1:0] LIM_YEAR = AW'(TMAX_L / 64'(U_YEAR));
    localparam logic [AW-1:0] LIM_WEEK = AW'(TMAX_L / 64'(U_WEEK));
    localparam logic [AW-1:0] LIM_DAY  = AW'(TMAX_L / 64'(U_DAY));
    localparam logic [AW-1:0] LIM_HOUR = AW'(TMAX_L / 64'(U_HOUR));
    localparam logic [AW-1:0] LIM_MIN  = AW'(TMAX_L / 64'(U_MIN));

    logic [UNIT_W-1:0]    w_uv;
    logic [AW-1:0]        w_lim;
    logic [LW+UNIT_W-1:0] w_lo;
    logic [HW+UNIT_W-1:0] w_hi;
    logic [PW-1:0]        w_prod;

    t_tag                 r_tag2;
    logic [LW+UNIT_W-1:0] r_lo;
    logic [HW+UNIT_W-1:0] r_hi;
    logic                 r_ovf;
    logic [AW-1:0]        r_acc2;
    t_tag                 r_tag3;
    logic [AW-1:0]        r_val3;

    assign w_uv = unit_value(i_tag.unit);

    always_comb begin
        case (i_tag.unit)
            UNIT_YEAR: w_lim = LIM_YEAR;
            UNIT_WEEK: w_lim = LIM_WEEK;
            UNIT_DAY:  w_lim = LIM_DAY;
            UNIT_HOUR: w_lim = LIM_HOUR;
            UNIT_MIN:  w_lim = LIM_MIN;
            default:   w_lim = TMAX;
        endcase
    end

    // split partial products
    assign w_lo = {{UNIT_W{1'b0}}, i_acc[LW-1:0]} * {{LW{1'b0}}, w_uv};
    assign w_hi = {{UNIT_W{1'b0}}, i_acc[AW-1:LW]} * {{HW{1'b0}}, w_uv};

    assign w_prod = {r_hi, {LW{1'b0}}} + {{HW{1'b0}}, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else if (i_en) begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo   <= w_lo;
            r_hi   <= w_hi;
            r_ovf  <= (i_acc > w_lim);
            r_acc2 <= i_acc;
            if (r_tag2.is_nul) begin
                r_val3 <= r_acc2;
            end else begin
                r_val3 <= r_ovf ? TMAX : w_prod[AW-1:0];
            end
        end
    end

    assign o_tag = r_tag3;
    assign o_val = r_val3;

endmodule

FILE: src/dtte_acc.sv
// dtte_acc: running total of the unit groups, final sum, time offset and result register
// depends on dtte_pkg and dtte_rsp_if; last stage before the result channel
module dtte_acc #(
    parameter int TIME_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dtte_pkg::t_tag       i_tag,
    input  logic [TIME_BITS-2:0] i_val,
    output logic                 o_stall,
    dtte_rsp_if.source           o_rsp
);
    import dtte_pkg::*;

    localparam int AW = TIME_BITS - 1;
    localparam logic [AW-1:0] TMAX = '1;

    logic [AW-1:0]  r_total, n_total;
    logic           r_v4;
    t_term          r_term4;
    logic [AW-1:0]  r_sum4;
    logic           r_out_valid;
    logic           r_ok;
    logic [EXP_W-1:0] r_value;

    logic           w_en;
    logic [AW:0]    w_tsum;
    logic [AW-1:0]  w_tsat;
    logic [AW-1:0]  w_now;
    logic [AW:0]    w_nsum;
    logic [AW-1:0]  w_r;
    logic           w_ok;
    logic [EXP_W-1:0] w_ext;

    assign o_stall = r_v4 && r_out_valid && !o_rsp.ready;
    assign w_en    = !o_stall;

    // operands never exceed all ones, so a carry means saturation
    assign w_tsum = {1'b0, r_total} + {1'b0, i_val};
    assign w_tsat = w_tsum[AW] ? TMAX : w_tsum[AW-1:0];

    always_comb begin
        n_total = r_total;
        if (i_tag.valid && i_tag.is_unit) begin
            n_total = w_tsat;
        end else if (i_tag.valid && i_tag.is_nul) begin
            n_total = '0;
        end
    end

    assign w_now  = (r_term4.now > NOW_W'(TMAX)) ? TMAX : r_term4.now[AW-1:0];
    assign w_nsum = {1'b0, r_sum4} + {1'b0, w_now};
    assign w_ok   = r_term4.kw || !r_term4.failed;

    always_comb begin
        if (r_term4.kw || r_term4.failed) begin
            w_r = '0;
        end else if (r_term4.absolute) begin
            w_r = w_nsum[AW] ? TMAX : w_nsum[AW-1:0];
        end else begin
            w_r = r_sum4;
        end
    end

    assign w_ext = EXP_W'(w_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_total <= n_total;
                r_v4    <= i_tag.valid && i_tag.is_nul;
            end
            if (r_v4 && w_en) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_term4 <= i_tag.term;
            r_sum4  <= w_tsat;
        end
        if (r_v4 && w_en) begin
            r_ok    <= w_ok;
            r_value <= (w_ok && r_term4.no_cache) ? ~w_ext : w_ext;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_ok;
    assign o_rsp.expiry_value = signed'(r_value);

endmodule
